// ===== hdl/tmie_pkg.sv =====
// shared types, constants and helpers of the tape machine instruction executor
package tmie_pkg;

	// tape and program geometry
	localparam int unsigned TAPE_CELLS    = 32768;
	localparam int unsigned PROGRAM_DEPTH = 4096;
	localparam int unsigned HEAD_W        = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;

	// item field widths
	localparam int unsigned FUNC_W  = 4;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned NEXT_W  = 13;
	localparam int unsigned BYTE_W  = 8;

	// packed stream widths
	localparam int unsigned S_DATA_W = 32;
	localparam int unsigned M_DATA_W = 24;

	// instruction codes, anything else acts as no-op
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LEFT  = 4'd0,
		FUNC_RIGHT = 4'd1,
		FUNC_INC   = 4'd2,
		FUNC_DEC   = 4'd3,
		FUNC_OPEN  = 4'd4,
		FUNC_CLOSE = 4'd5,
		FUNC_OUT   = 4'd6,
		FUNC_IN    = 4'd7,
		FUNC_NOP   = 4'd8
	} func_t;

	// index plus one, clamped to the past-end index
	function automatic logic [NEXT_W-1:0] succ_index(input logic [INDEX_W-1:0] idx);
		logic [NEXT_W-1:0] n;
		n = {{(NEXT_W-INDEX_W){1'b0}}, idx} + NEXT_W'(1);
		if (n > NEXT_W'(PROGRAM_DEPTH)) begin
			n = NEXT_W'(PROGRAM_DEPTH);
		end
		return n;
	endfunction

endpackage

// ===== hdl/tape_machine_instruction_executor_core.sv =====
// tape machine instruction executor: tape memory, head register and result stage
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-----------------------------------------------
//  s_*       | in  | s_tvalid/s_tready| tdata: instr_index, jump_target, in_byte;
//            |     |                  | tuser: func
//  m_*       | out | m_tvalid/m_tready| tdata: next_index, out_byte; tuser: out_valid
//
//  one item per cycle sustained while the output is not stalled; each item passes stage s1, then
//  the output register (tape read at accept, read-modify-write of the cell in stage s1 into the output register)
//  the cell written by one item is forwarded to the next item reading it the same cycle
//  after reset the tape is swept to zero with s_tready low
//  a stalled output holds stage s1 and in turn s_tready, no item is dropped
module tape_machine_instruction_executor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [11:0] instr_index, [23:12] jump_target, [31:24] in_byte
	input  logic [tmie_pkg::S_DATA_W-1:0]     s_tdata,
	// [3:0] func
	input  logic [tmie_pkg::FUNC_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [12:0] next_index, [20:13] out_byte, [23:21] zero
	output logic [tmie_pkg::M_DATA_W-1:0]     m_tdata,
	// [0] out_valid
	output logic                              m_tuser
);

	localparam int unsigned HW = tmie_pkg::HEAD_W;
	localparam int unsigned IW = tmie_pkg::INDEX_W;
	localparam int unsigned BW = tmie_pkg::BYTE_W;
	localparam int unsigned NW = tmie_pkg::NEXT_W;
	localparam logic [HW-1:0] LAST_CELL = HW'(tmie_pkg::TAPE_CELLS - 1);

	// tape memory
	logic [BW-1:0] tape_mem [tmie_pkg::TAPE_CELLS];

	// control registers
	logic          clr_q;
	logic [HW-1:0] clr_addr_q;
	logic [HW-1:0] head_q;
	logic          vld_s1;

	// stage s1 payload
	tmie_pkg::func_t func_s1;
	logic [IW-1:0]   idx_s1;
	logic [IW-1:0]   tgt_s1;
	logic [BW-1:0]   inb_s1;
	logic [HW-1:0]   addr_s1;
	logic            fwd_s1;
	logic [BW-1:0]   fwd_data_s1;
	logic [BW-1:0]   rd_data_s1;

	// handshakes and write port
	logic            accept;
	logic            s1_fire;
	logic            out_free;
	logic            wr_en;
	logic [HW-1:0]   wr_addr;
	logic [BW-1:0]   wr_data;
	tmie_pkg::func_t func_in;

	// stage s1 results
	logic          cell_s1;
	logic [BW-1:0] cur_cell;
	logic          exec_wr;
	logic [BW-1:0] exec_data;
	logic [NW-1:0] next_idx;
	logic          emit;
	logic [BW-1:0] emit_byte;

	assign func_in  = tmie_pkg::func_t'(s_tuser);
	assign out_free = !m_tvalid || m_tready;
	assign s1_fire  = vld_s1 && out_free;
	assign s_tready = !clr_q && (!vld_s1 || s1_fire);
	assign accept   = s_tvalid && s_tready;

	// cell value with forwarding of a write that coincided with the read
	assign cur_cell = fwd_s1 ? fwd_data_s1 : rd_data_s1;
	assign cell_s1  = (cur_cell != '0);

	// execute the instruction held in s1
	always_comb begin
		exec_wr   = 1'b0;
		exec_data = cur_cell;
		next_idx  = tmie_pkg::succ_index(idx_s1);
		emit      = 1'b0;
		emit_byte = '0;
		unique case (func_s1)
			tmie_pkg::FUNC_INC: begin
				exec_wr   = 1'b1;
				exec_data = cur_cell + BW'(1);
			end
			tmie_pkg::FUNC_DEC: begin
				exec_wr   = 1'b1;
				exec_data = cur_cell - BW'(1);
			end
			tmie_pkg::FUNC_IN: begin
				exec_wr   = 1'b1;
				exec_data = inb_s1;
			end
			tmie_pkg::FUNC_OPEN: begin
				if (!cell_s1) begin
					next_idx = tmie_pkg::succ_index(tgt_s1);
				end
			end
			tmie_pkg::FUNC_CLOSE: begin
				if (cell_s1) begin
					next_idx = tmie_pkg::succ_index(tgt_s1);
				end
			end
			tmie_pkg::FUNC_OUT: begin
				emit      = 1'b1;
				emit_byte = cur_cell;
			end
			default: begin
			end
		endcase
	end

	// write port: clearing sweep or cell write back
	always_comb begin
		if (clr_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = s1_fire && exec_wr;
			wr_addr = addr_s1;
			wr_data = exec_data;
		end
	end

	// tape memory ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tape_mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_data_s1 <= tape_mem[head_q];
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == LAST_CELL) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + HW'(1);
			end
		end
	end

	// head moves at accept, independent of the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			unique case (func_in)
				tmie_pkg::FUNC_LEFT: begin
					head_q <= (head_q == '0) ? LAST_CELL : head_q - HW'(1);
				end
				tmie_pkg::FUNC_RIGHT: begin
					head_q <= (head_q == LAST_CELL) ? '0 : head_q + HW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// stage s1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage s1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func_in;
			idx_s1      <= s_tdata[IW-1:0];
			tgt_s1      <= s_tdata[2*IW-1:IW];
			inb_s1      <= s_tdata[2*IW+BW-1:2*IW];
			addr_s1     <= head_q;
			fwd_s1      <= wr_en && (wr_addr == head_q);
			fwd_data_s1 <= wr_data;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s1_fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			m_tdata <= {(tmie_pkg::M_DATA_W-NW-BW)'(0), emit_byte, next_idx};
			m_tuser <= emit;
		end
	end

	// no item enters while the tape is being cleared
	assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> !accept)
		else $error("item accepted during clearing sweep");

	// the sweep owns the write port, so no instruction may retire during it
	assert property (@(posedge clk) disable iff (!arst_n) clr_q |-> !vld_s1)
		else $error("instruction in s1 during clearing sweep");

	// a blocked s1 item stays put
	assert property (@(posedge clk) disable iff (!arst_n) (vld_s1 && !out_free) |=> vld_s1)
		else $error("s1 item lost under output stall");

	// a new result only appears after an s1 item retired
	assert property (@(posedge clk) disable iff (!arst_n) $rose(m_tvalid) |-> $past(s1_fire))
		else $error("result without retired instruction");

	// out_byte is zero unless a byte is emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[NW+BW-1:NW] == '0))
		else $error("out_byte nonzero without out_valid");

endmodule

// ===== bench/tape_machine_instruction_executor_core_test.sv =====
// self-checking bench for the tape machine instruction executor core
`timescale 1ns / 100ps

module tape_machine_instruction_executor_core_test;

	localparam int unsigned WATCHDOG_LIMIT = 200000;

	// one executed instruction as seen on the result stream
	typedef struct packed {
		logic [tmie_pkg::NEXT_W-1:0] next_index;
		logic                        out_valid;
		logic [tmie_pkg::BYTE_W-1:0] out_byte;
	} exec_result_t;

	// keeps its own tape and head, predicts each result and compares in order
	class exec_scoreboard;
		bit [tmie_pkg::BYTE_W-1:0] cells [tmie_pkg::TAPE_CELLS];
		bit [tmie_pkg::HEAD_W-1:0] head_pos;
		exec_result_t    pending_results[$];
		int unsigned     checked;
		int unsigned     errors;
		int unsigned     emitted;
		int unsigned     jumps;
		int unsigned     wraps;

		function new();
			head_pos = '0;
			checked  = 0;
			errors   = 0;
			emitted  = 0;
			jumps    = 0;
			wraps    = 0;
		endfunction

		// index plus one, held at the past-end index
		function logic [tmie_pkg::NEXT_W-1:0] next_after(logic [tmie_pkg::INDEX_W-1:0] idx);
			logic [tmie_pkg::NEXT_W:0] n;
			n = {2'b00, idx} + (tmie_pkg::NEXT_W+1)'(1);
			if (n > (tmie_pkg::NEXT_W+1)'(tmie_pkg::PROGRAM_DEPTH)) begin
				n = (tmie_pkg::NEXT_W+1)'(tmie_pkg::PROGRAM_DEPTH);
			end
			return n[tmie_pkg::NEXT_W-1:0];
		endfunction

		// execute one accepted instruction and queue what the block must return
		function void note_item(logic [tmie_pkg::FUNC_W-1:0] op,
				logic [tmie_pkg::INDEX_W-1:0] idx, logic [tmie_pkg::INDEX_W-1:0] tgt,
				logic [tmie_pkg::BYTE_W-1:0] in_b);
			exec_result_t              r;
			bit [tmie_pkg::BYTE_W-1:0] cur_cell;
			cur_cell     = cells[head_pos];
			r.next_index = next_after(idx);
			r.out_valid  = 1'b0;
			r.out_byte   = '0;
			case (op)
				tmie_pkg::FUNC_LEFT: begin
					if (head_pos == 0) begin
						head_pos = tmie_pkg::HEAD_W'(tmie_pkg::TAPE_CELLS - 1);
						wraps++;
					end else begin
						head_pos = head_pos - 1'b1;
					end
				end
				tmie_pkg::FUNC_RIGHT: begin
					if (head_pos == tmie_pkg::HEAD_W'(tmie_pkg::TAPE_CELLS - 1)) begin
						head_pos = '0;
						wraps++;
					end else begin
						head_pos = head_pos + 1'b1;
					end
				end
				tmie_pkg::FUNC_INC: cells[head_pos] = cur_cell + 1'b1;
				tmie_pkg::FUNC_DEC: cells[head_pos] = cur_cell - 1'b1;
				tmie_pkg::FUNC_OPEN: begin
					if (cur_cell == 0) begin
						r.next_index = next_after(tgt);
						jumps++;
					end
				end
				tmie_pkg::FUNC_CLOSE: begin
					if (cur_cell != 0) begin
						r.next_index = next_after(tgt);
						jumps++;
					end
				end
				tmie_pkg::FUNC_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte  = cur_cell;
					emitted++;
				end
				tmie_pkg::FUNC_IN: cells[head_pos] = in_b;
				default: ;
			endcase
			pending_results.push_back(r);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(exec_result_t got);
			exec_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result next_index %0d out_valid %0d out_byte %0d",
					$time, got.next_index, got.out_valid, got.out_byte);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.next_index !== want.next_index) begin
				$display("%0t: next_index expected %0d actual %0d",
					$time, want.next_index, got.next_index);
				errors++;
			end
			if (got.out_valid !== want.out_valid) begin
				$display("%0t: out_valid expected %0d actual %0d",
					$time, want.out_valid, got.out_valid);
				errors++;
			end
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %0d actual %0d",
					$time, want.out_byte, got.out_byte);
				errors++;
			end
		endfunction
	endclass

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [tmie_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic [tmie_pkg::FUNC_W-1:0]   s_tuser  = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [tmie_pkg::M_DATA_W-1:0] m_tdata;
	logic                          m_tuser;

	exec_scoreboard sb;
	int unsigned    sent           = 0;
	int unsigned    send_idle_pct  = 0;
	int unsigned    recv_stall_pct = 0;
	int unsigned    quiet_cycles   = 0;

	tape_machine_instruction_executor_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// observe both handshakes, feed the scoreboard, watch for a hang
	always @(posedge clk) begin
		exec_result_t got;
		if (s_tvalid && s_tready) begin
			sb.note_item(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[31:24]);
		end
		if (m_tvalid && m_tready) begin
			got.next_index = m_tdata[12:0];
			got.out_byte   = m_tdata[20:13];
			got.out_valid  = m_tuser;
			sb.check_result(got);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("tape_machine_instruction_executor_core verification failed");
			$finish;
		end
	end

	// present one item, with random idle cycles ahead of it, and hold until taken
	task automatic send_item(input logic [tmie_pkg::FUNC_W-1:0] op,
			input logic [tmie_pkg::INDEX_W-1:0] idx, input logic [tmie_pkg::INDEX_W-1:0] tgt,
			input logic [tmie_pkg::BYTE_W-1:0] in_b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {in_b, tgt, idx};
		do begin
			@(posedge clk);
		end while (!s_tready);
		sent++;
	endtask

	// stop sending until every item has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (sb.checked != sent) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [tmie_pkg::INDEX_W-1:0] pick_index();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return tmie_pkg::INDEX_W'($urandom());
	endfunction

	// structured snippets (counted loops, forwarding bursts), unused opcodes and random instructions
	task automatic random_items(input int unsigned n);
		int unsigned count;
		int unsigned r;
		int unsigned k;
		logic [tmie_pkg::INDEX_W-1:0] here;
		logic [tmie_pkg::INDEX_W-1:0] far;
		count = 0;
		while (count < n) begin
			r    = $urandom_range(0, 99);
			here = pick_index();
			far  = pick_index();
			if (r < 25) begin
				// load a small count, then a decrement loop that runs it down to zero
				k = $urandom_range(0, 5);
				send_item(tmie_pkg::FUNC_IN, here, far, tmie_pkg::BYTE_W'(k));
				send_item(tmie_pkg::FUNC_OPEN, here + 1'b1, far,
					tmie_pkg::BYTE_W'($urandom()));
				for (int unsigned i = 0; i < k; i++) begin
					send_item(tmie_pkg::FUNC_DEC, here + 2'd2, far,
						tmie_pkg::BYTE_W'($urandom()));
					send_item(tmie_pkg::FUNC_CLOSE, far, here + 1'b1,
						tmie_pkg::BYTE_W'($urandom()));
				end
				send_item(tmie_pkg::FUNC_OUT, far + 1'b1, here, tmie_pkg::BYTE_W'($urandom()));
				count += 3 + 2 * k;
			end else if (r < 40) begin
				// back-to-back updates of one cell
				k = $urandom_range(1, 4);
				for (int unsigned i = 0; i < k; i++) begin
					send_item(($urandom_range(0, 1) != 0) ? tmie_pkg::FUNC_INC :
						tmie_pkg::FUNC_DEC, here, far, tmie_pkg::BYTE_W'($urandom()));
				end
				send_item(tmie_pkg::FUNC_OUT, here, far, tmie_pkg::BYTE_W'($urandom()));
				count += k + 1;
			end else if (r < 48) begin
				// unused opcodes and raw noise
				send_item(tmie_pkg::FUNC_W'($urandom_range(9, 15)), here, far,
					tmie_pkg::BYTE_W'($urandom()));
				count++;
			end else begin
				send_item(tmie_pkg::FUNC_W'($urandom_range(0, 8)), here, far,
					tmie_pkg::BYTE_W'($urandom()));
				count++;
			end
		end
	endtask

	// extremes of every field, every opcode, wraps of head and cell, the last program index
	task automatic run_directed();
		send_item(tmie_pkg::FUNC_OUT,   12'd0,    12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_DEC,   12'd1,    12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_OUT,   12'd2,    12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_INC,   12'd3,    12'd0,    8'hff);
		send_item(tmie_pkg::FUNC_OPEN,  12'd4,    12'd4095, 8'd0);
		send_item(tmie_pkg::FUNC_LEFT,  12'd5,    12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_IN,    12'd6,    12'd0,    8'hff);
		send_item(tmie_pkg::FUNC_CLOSE, 12'd4095, 12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_OUT,   12'd7,    12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_RIGHT, 12'd8,    12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_IN,    12'd9,    12'd0,    8'h80);
		send_item(tmie_pkg::FUNC_OPEN,  12'd4095, 12'd100,  8'd0);
		send_item(tmie_pkg::FUNC_DEC,   12'd10,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_OUT,   12'd11,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_IN,    12'd12,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_CLOSE, 12'd0,    12'd4095, 8'd0);
		send_item(tmie_pkg::FUNC_OPEN,  12'd13,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_NOP,   12'd4095, 12'd4095, 8'hff);
		send_item(tmie_pkg::FUNC_W'(9), 12'h555,  12'haaa,  8'h55);
		send_item(tmie_pkg::FUNC_W'(15), 12'd4095, 12'd4095, 8'hff);
		send_item(tmie_pkg::FUNC_RIGHT, 12'd14,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_LEFT,  12'd15,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_LEFT,  12'd16,   12'd0,    8'd0);
		send_item(tmie_pkg::FUNC_OUT,   12'haaa,  12'h555,  8'haa);
	endtask

	// main sequence
	initial begin
		sb = new();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, no idling
		run_directed();
		wait_for_results();

		// random, no idling
		random_items(240);
		wait_for_results();

		// sender idle, with one full drain in the middle
		send_idle_pct = 78;
		random_items(120);
		wait_for_results();
		random_items(120);
		wait_for_results();

		// receiver stalling
		send_idle_pct  = 0;
		recv_stall_pct = 78;
		random_items(240);
		wait_for_results();

		// both sides idling
		send_idle_pct  = 30;
		recv_stall_pct = 30;
		random_items(240);
		wait_for_results();

		repeat (8) @(posedge clk);
		$display("run covered %0d instructions: %0d bytes out, %0d branches taken, %0d head wraps",
			sent, sb.emitted, sb.jumps, sb.wraps);
		$display("idling phases: none, sender 78%%, receiver 78%%, both 30%%; %0d mismatches",
			sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("tape_machine_instruction_executor_core verification clean");
		end else begin
			$display("tape_machine_instruction_executor_core verification failed");
		end
		$finish;
	end

endmodule

// ===== tape_machine_instruction_executor_core.f =====
hdl/tmie_pkg.sv
hdl/tape_machine_instruction_executor_core.sv
bench/tape_machine_instruction_executor_core_test.sv
